### rtl/core/cllp_pkg.sv
package cllp_pkg;

  localparam int unsigned POOL_DEPTH = 16;
  localparam int unsigned NUM_LISTS  = 4;

  localparam int unsigned SLOT_W     = $clog2(POOL_DEPTH);
  localparam int unsigned LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int unsigned LIST_IDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);
  localparam logic signed [31:0] EMPTY_MARK = -32'sd999;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_WALK   = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

### rtl/core/cllp_in_if.sv
interface cllp_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic        [1:0]  list_id;
  logic signed [31:0] value;

  modport source (output valid, func, list_id, value, input ready);
  modport sink   (input valid, func, list_id, value, output ready);
endinterface

### rtl/core/cllp_out_if.sv
interface cllp_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [3:0]  slot;
  logic signed [31:0] elem;
  logic               last;

  modport source (output valid, status, slot, elem, last, input ready);
  modport sink   (input valid, status, slot, elem, last, output ready);
endinterface

### rtl/core/cursor_linked_list_pool.sv
// Operation: insert and delete read the slot memory, then write back and give their result;
//   pool-full and empty-list errors register their result straight from the idle state.
// A walk does one synchronous read of the slot memories per node. A new item is taken only
//   in the idle state, once the last one is through. The output register stalls it all.
// Reset: asynchronous, active low; list heads go null, the free head to the top slot and
//   every slot's written flag clears, so unwritten slots read as -999 and link downward.
module cursor_linked_list_pool (
  input  logic clk_i,
  input  logic rst_ni,
  cllp_in_if.sink    in_i,
  cllp_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;

  localparam logic [cllp_pkg::SLOT_W-1:0] LAST_CNT =
    cllp_pkg::SLOT_W'(cllp_pkg::POOL_DEPTH - 1);

  // Slot memories: element and link, one synchronous read port, one write port.
  logic signed [31:0]               elem_mem [cllp_pkg::POOL_DEPTH];
  logic [cllp_pkg::LINK_W-1:0]      link_mem [cllp_pkg::POOL_DEPTH];
  logic [cllp_pkg::POOL_DEPTH-1:0]  written_q;

  logic                             rd_en;
  logic [cllp_pkg::SLOT_W-1:0]      rd_addr;
  logic signed [31:0]               elem_raw_q;
  logic [cllp_pkg::LINK_W-1:0]      link_raw_q;
  logic                             rd_written_q;
  logic [cllp_pkg::SLOT_W-1:0]      rd_addr_q;
  logic signed [31:0]               elem_rd;
  logic [cllp_pkg::LINK_W-1:0]      link_rd;
  logic [cllp_pkg::LINK_W-1:0]      link_reset;

  logic                             wr_en;
  logic [cllp_pkg::SLOT_W-1:0]      wr_addr;
  logic signed [31:0]               wr_elem;
  logic [cllp_pkg::LINK_W-1:0]      wr_link;

  // Control and list state
  logic [1:0]                       state_q, state_d;
  logic [1:0]                       func_q, func_d;
  logic [cllp_pkg::LIST_IDX_W-1:0]  lid_q, lid_d;
  logic signed [31:0]               value_q, value_d;
  logic [cllp_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic [cllp_pkg::SLOT_W-1:0]      cnt_q, cnt_d;
  logic [cllp_pkg::LINK_W-1:0]      free_head_q, free_head_d;
  logic [cllp_pkg::LINK_W-1:0]      heads_q [cllp_pkg::NUM_LISTS];
  logic [cllp_pkg::LINK_W-1:0]      heads_d [cllp_pkg::NUM_LISTS];

  // Output register
  logic                             out_valid_q, out_valid_d;
  logic [1:0]                       out_status_q, out_status_d;
  logic [3:0]                       out_slot_q, out_slot_d;
  logic signed [31:0]               out_elem_q, out_elem_d;
  logic                             out_last_q, out_last_d;

  logic                             out_free;
  logic                             accept;
  logic [cllp_pkg::LIST_IDX_W-1:0]  in_lid;
  logic [cllp_pkg::LINK_W-1:0]      in_head;
  logic                             walk_fin;

  // Memory arrays: written and read in clocked blocks, read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      elem_mem[wr_addr] <= wr_elem;
      link_mem[wr_addr] <= wr_link;
    end
    if (rd_en) begin
      elem_raw_q   <= elem_mem[rd_addr];
      link_raw_q   <= link_mem[rd_addr];
      rd_written_q <= written_q[rd_addr];
      rd_addr_q    <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[wr_addr] <= 1'b1;
    end
  end

  // A slot never written reads as its reset content: -999 and a link one slot down (null for slot 0).
  assign link_reset = (rd_addr_q == '0) ? cllp_pkg::NULL_LINK
                                        : cllp_pkg::LINK_W'(rd_addr_q) - 1'b1;
  assign elem_rd    = rd_written_q ? elem_raw_q : cllp_pkg::EMPTY_MARK;
  assign link_rd    = rd_written_q ? link_raw_q : link_reset;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;
  assign in_lid    = cllp_pkg::LIST_IDX_W'(in_i.list_id % cllp_pkg::NUM_LISTS);
  assign in_head   = heads_q[in_lid];
  assign walk_fin  = (link_rd >= cllp_pkg::NULL_LINK) || (cnt_q == LAST_CNT);

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    lid_d        = lid_q;
    value_d      = value_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    free_head_d  = free_head_q;
    heads_d      = heads_q;
    rd_en        = 1'b0;
    rd_addr      = slot_q;
    wr_en        = 1'b0;
    wr_addr      = slot_q;
    wr_elem      = value_q;
    wr_link      = free_head_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_elem_d   = out_elem_q;
    out_last_d   = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d  = in_i.func;
          lid_d   = in_lid;
          value_d = in_i.value;
          cnt_d   = '0;
          case (in_i.func)
            cllp_pkg::FUNC_INSERT: begin
              if (free_head_q >= cllp_pkg::NULL_LINK) begin
                // Pool full: report and change nothing.
                out_valid_d  = 1'b1;
                out_status_d = cllp_pkg::STATUS_FULL;
                out_slot_d   = '0;
                out_elem_d   = in_i.value;
                out_last_d   = 1'b1;
              end else begin
                // Fetch the free slot's link: it becomes the new free head.
                rd_en   = 1'b1;
                rd_addr = free_head_q[cllp_pkg::SLOT_W-1:0];
                slot_d  = free_head_q[cllp_pkg::SLOT_W-1:0];
                state_d = ST_UPDATE;
              end
            end
            cllp_pkg::FUNC_DELETE, cllp_pkg::FUNC_WALK: begin
              if (in_head >= cllp_pkg::NULL_LINK) begin
                // Empty list: report and change nothing.
                out_valid_d  = 1'b1;
                out_status_d = cllp_pkg::STATUS_EMPTY;
                out_slot_d   = '0;
                out_elem_d   = '0;
                out_last_d   = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = in_head[cllp_pkg::SLOT_W-1:0];
                slot_d  = in_head[cllp_pkg::SLOT_W-1:0];
                state_d = (in_i.func == cllp_pkg::FUNC_WALK) ? ST_WALK : ST_UPDATE;
              end
            end
            default: begin
              // Unused code: drop the item.
            end
          endcase
        end
      end

      ST_UPDATE: begin
        // Write back only once the result has a place to go.
        if (out_free) begin
          wr_en        = 1'b1;
          wr_addr      = slot_q;
          out_valid_d  = 1'b1;
          out_status_d = cllp_pkg::STATUS_OK;
          out_slot_d   = 4'(slot_q);
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
          if (func_q == cllp_pkg::FUNC_INSERT) begin
            wr_elem        = value_q;
            wr_link        = heads_q[lid_q];
            free_head_d    = link_rd;
            heads_d[lid_q] = cllp_pkg::LINK_W'(slot_q);
            out_elem_d     = value_q;
          end else begin
            wr_elem        = cllp_pkg::EMPTY_MARK;
            wr_link        = free_head_q;
            free_head_d    = cllp_pkg::LINK_W'(slot_q);
            heads_d[lid_q] = link_rd;
            out_elem_d     = elem_rd;
          end
        end
      end

      ST_WALK: begin
        // Emit the node just read and follow its link.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = cllp_pkg::STATUS_OK;
          out_slot_d   = 4'(slot_q);
          out_elem_d   = elem_rd;
          out_last_d   = walk_fin;
          if (walk_fin) begin
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = link_rd[cllp_pkg::SLOT_W-1:0];
            slot_d  = link_rd[cllp_pkg::SLOT_W-1:0];
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      free_head_q <= cllp_pkg::LINK_W'(cllp_pkg::POOL_DEPTH - 1);
      for (int i = 0; i < cllp_pkg::NUM_LISTS; i++) begin
        heads_q[i] <= cllp_pkg::NULL_LINK;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      free_head_q <= free_head_d;
      heads_q     <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    lid_q        <= lid_d;
    value_q      <= value_d;
    slot_q       <= slot_d;
    cnt_q        <= cnt_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_elem_q   <= out_elem_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.slot   = out_slot_q;
  assign out_o.elem   = out_elem_q;
  assign out_o.last   = out_last_q;

endmodule

### rtl/core/cllp_checker.sv
module cllp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [3:0]  out_slot_i,
  input logic        out_last_i
);

  // A waiting result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Only the three defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == cllp_pkg::STATUS_OK ||
                     out_status_i == cllp_pkg::STATUS_FULL ||
                     out_status_i == cllp_pkg::STATUS_EMPTY))
    else $error("undefined status code");

  // An error ends its item at once and names slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != cllp_pkg::STATUS_OK |-> out_last_i && out_slot_i == '0)
    else $error("error result not final");

  // A walk continues only through good nodes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == cllp_pkg::STATUS_OK)
    else $error("non-final result carries error");

endmodule

bind cursor_linked_list_pool cllp_checker u_cllp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_status_i(out_o.status),
  .out_slot_i  (out_o.slot),
  .out_last_i  (out_o.last)
);
